[design/dmsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmsp_pkg
// Shared widths, constants and types of the dual motor speed PID unit.
// ----------------------------------------------------------------------------
package dmsp_pkg;

  localparam int DATA_W        = 16;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int ACC_W         = PROD_W + 2;
  localparam int LIMIT_W       = 15;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP    = 3'd0,
    CFG_KI    = 3'd1,
    CFG_KD    = 3'd2,
    CFG_LIMIT = 3'd3
  } cfg_reg_e;

  // Stage load enables from the pipeline control to each lane
  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } ctrl_t;

endpackage

[design/dmsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmsp_in_if / dmsp_out_if
// Valid/ready channels for control ticks and drive results.
// ----------------------------------------------------------------------------
interface dmsp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [dmsp_pkg::DATA_W-1:0]  target_speed_a;
  logic signed [dmsp_pkg::DATA_W-1:0]  measured_speed_a;
  logic signed [dmsp_pkg::DATA_W-1:0]  target_speed_b;
  logic signed [dmsp_pkg::DATA_W-1:0]  measured_speed_b;
  logic                                clear_integral;

  modport source (
    output valid, target_speed_a, measured_speed_a, target_speed_b,
           measured_speed_b, clear_integral,
    input  ready
  );
  modport sink (
    input  valid, target_speed_a, measured_speed_a, target_speed_b,
           measured_speed_b, clear_integral,
    output ready
  );
endinterface

interface dmsp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dmsp_pkg::DATA_W-1:0]  drive_a;
  logic signed [dmsp_pkg::DATA_W-1:0]  drive_b;

  modport source (output valid, drive_a, drive_b, input ready);
  modport sink (input valid, drive_a, drive_b, output ready);
endinterface

[design/dmsp_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmsp_lane
// One motor's PID: error history update, three gain products, sum and clamp.
// ----------------------------------------------------------------------------
module dmsp_lane #(
  parameter int GAIN_FRAC_BITS = dmsp_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dmsp_pkg::ctrl_t                       ctrl_i,
  input  logic                                  clear_i,
  input  logic signed [dmsp_pkg::DATA_W-1:0]    target_i,
  input  logic signed [dmsp_pkg::DATA_W-1:0]    measured_i,
  input  logic signed [dmsp_pkg::DATA_W-1:0]    kp_i,
  input  logic signed [dmsp_pkg::DATA_W-1:0]    ki_i,
  input  logic signed [dmsp_pkg::DATA_W-1:0]    kd_i,
  input  logic        [dmsp_pkg::LIMIT_W-1:0]   limit_i,
  output logic signed [dmsp_pkg::DATA_W-1:0]    drive_o
);

  logic signed [dmsp_pkg::DATA_W-1:0] err;
  logic signed [dmsp_pkg::DATA_W-1:0] sum_d, sum_q;
  logic signed [dmsp_pkg::DATA_W-1:0] prev_q, older_q;
  logic signed [dmsp_pkg::DATA_W-1:0] diff_d, diff_q;
  logic signed [dmsp_pkg::PROD_W-1:0] prod_p_q, prod_i_q, prod_d_q;
  logic signed [dmsp_pkg::ACC_W-1:0]  acc, shifted, lim_pos, lim_neg, sat;

  assign err    = target_i - measured_i;
  assign sum_d  = (clear_i ? '0 : sum_q) + err;
  assign diff_d = prev_q - older_q;

  // Stage 1: history update; sum_q and prev_q double as the stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      prev_q  <= '0;
      older_q <= '0;
    end else if (ctrl_i.s1_en) begin
      sum_q   <= sum_d;
      prev_q  <= err;
      older_q <= prev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      diff_q <= diff_d;
    end
  end

  // Stage 2: gain products
  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_en) begin
      prod_p_q <= prev_q * kp_i;
      prod_i_q <= sum_q * ki_i;
      prod_d_q <= diff_q * kd_i;
    end
  end

  // Stage 3 logic: sum, floor shift, symmetric clamp
  always_comb begin
    acc     = dmsp_pkg::ACC_W'(prod_p_q) + dmsp_pkg::ACC_W'(prod_i_q)
            + dmsp_pkg::ACC_W'(prod_d_q);
    shifted = acc >>> GAIN_FRAC_BITS;
    lim_pos = $signed({{(dmsp_pkg::ACC_W - dmsp_pkg::LIMIT_W){1'b0}}, limit_i});
    lim_neg = -lim_pos;
    if (shifted > lim_pos) begin
      sat = lim_pos;
    end else if (shifted < lim_neg) begin
      sat = lim_neg;
    end else begin
      sat = shifted;
    end
    drive_o = sat[dmsp_pkg::DATA_W-1:0];
  end

  a_clear_restarts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.s1_en && clear_i |=> sum_q == $past(err))
    else $error("error sum not restarted on clear");

  a_history_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.s1_en |=> older_q == $past(prev_q))
    else $error("error history did not shift");

endmodule

[design/dmsp_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmsp_merge
// Pipeline control and the output register that joins both lane results.
// ----------------------------------------------------------------------------
module dmsp_merge (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  output dmsp_pkg::ctrl_t                      ctrl_o,
  input  logic signed [dmsp_pkg::DATA_W-1:0]   drive_a_i,
  input  logic signed [dmsp_pkg::DATA_W-1:0]   drive_b_i,
  dmsp_out_if.source                           out_o
);

  logic s1_v_q, s2_v_q, out_v_q;
  logic adv_out, adv2, adv1;
  logic signed [dmsp_pkg::DATA_W-1:0] drive_a_q, drive_b_q;

  assign adv_out = !out_v_q || out_o.ready;
  assign adv2    = !s2_v_q || adv_out;
  assign adv1    = !s1_v_q || adv2;

  assign in_ready_o   = adv1;
  assign ctrl_o.s1_en = in_valid_i && adv1;
  assign ctrl_o.s2_en = s1_v_q && adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1)    s1_v_q  <= in_valid_i;
      if (adv2)    s2_v_q  <= s1_v_q;
      if (adv_out) out_v_q <= s2_v_q;
    end
  end

  // Hold the result while the request is stalled
  always_ff @(posedge clk_i) begin
    if (adv_out && s2_v_q) begin
      drive_a_q <= drive_a_i;
      drive_b_q <= drive_b_i;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.drive_a = drive_a_q;
  assign out_o.drive_b = drive_b_q;

  a_result_from_stage2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s2_v_q))
    else $error("result raised without a product stage entry");

endmodule

[design/dual_motor_speed_pid_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_speed_pid_unit
// One request per cycle while the output is not held by back-pressure;
// stages are error/history update, gain multiply, and sum/shift/clamp
// into the output register.
// Reset: gains clear to zero, output limit to 1500, error history to zero.
// ----------------------------------------------------------------------------
module dual_motor_speed_pid_unit #(
  parameter int GAIN_FRAC_BITS = dmsp_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dmsp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dmsp_pkg::DATA_W-1:0]          cfg_data_i,
  dmsp_in_if.sink                              in_i,
  dmsp_out_if.source                           out_o
);

  logic signed [dmsp_pkg::DATA_W-1:0] kp_q, ki_q, kd_q;
  logic        [dmsp_pkg::LIMIT_W-1:0] limit_q;
  dmsp_pkg::ctrl_t                     ctrl;
  logic signed [dmsp_pkg::DATA_W-1:0] drive_a, drive_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      limit_q <= dmsp_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (dmsp_pkg::cfg_reg_e'(cfg_idx_i))
        dmsp_pkg::CFG_KP:    kp_q    <= cfg_data_i;
        dmsp_pkg::CFG_KI:    ki_q    <= cfg_data_i;
        dmsp_pkg::CFG_KD:    kd_q    <= cfg_data_i;
        dmsp_pkg::CFG_LIMIT: limit_q <= cfg_data_i[dmsp_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  dmsp_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .clear_i    (in_i.clear_integral),
    .target_i   (in_i.target_speed_a),
    .measured_i (in_i.measured_speed_a),
    .kp_i       (kp_q),
    .ki_i       (ki_q),
    .kd_i       (kd_q),
    .limit_i    (limit_q),
    .drive_o    (drive_a)
  );

  dmsp_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .clear_i    (in_i.clear_integral),
    .target_i   (in_i.target_speed_b),
    .measured_i (in_i.measured_speed_b),
    .kp_i       (kp_q),
    .ki_i       (ki_q),
    .kd_i       (kd_q),
    .limit_i    (limit_q),
    .drive_o    (drive_b)
  );

  dmsp_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .ctrl_o     (ctrl),
    .drive_a_i  (drive_a),
    .drive_b_i  (drive_b),
    .out_o      (out_o)
  );

  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input stalled without output backpressure");

  a_drive_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.drive_a <= $signed({1'b0, limit_q})
                 && out_o.drive_a >= -$signed({1'b0, limit_q})
                 && out_o.drive_b <= $signed({1'b0, limit_q})
                 && out_o.drive_b >= -$signed({1'b0, limit_q}))
    else $error("drive value beyond output limit");

endmodule
